// ===== hw/rtl/hslrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB package
// Beat types, stage enables and the fixed constants of the color conversion.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] light_pct;
    } hsl_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_out_t;

    // One load enable per pipeline stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned LEVEL_W = 14;   // Q and P, up to 10000
    localparam int unsigned RAMP_W  = 20;   // ramp times 60, up to 600000
    localparam int unsigned SLOPE_W = 6;    // degrees into a slope, 0..60
    localparam int unsigned SCALE_W = 24;   // ramp times 17
    localparam int unsigned QIN_W   = 18;   // scaled ramp after the shift
    localparam int unsigned RECIP_W = 19;
    localparam int unsigned PROD_W  = QIN_W + RECIP_W;

    localparam logic [HUE_W-1:0] FULL_TURN  = 9'd360;
    localparam logic [HUE_W-1:0] THIRD_TURN = 9'd120;
    localparam logic [HUE_W-1:0] TWO_THIRDS = 9'd240;
    localparam logic [HUE_W-1:0] SIXTH_TURN = 9'd60;
    localparam logic [HUE_W-1:0] HALF_TURN  = 9'd180;

    localparam logic [PCT_W-1:0] PCT_ONE  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;

    // 255/600000 reduces to 17/40000, and 40000 = 64 * 625. The divide by
    // 625 is a multiply by ceil(2^28 / 625), exact for all quotients here.
    localparam int unsigned     SCALE_SHIFT = 6;
    localparam int unsigned     RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_625 = 19'd429497;

    localparam logic [8:0] CHAN_MAX = 9'd255;

endpackage

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
// Throughput: one color per cycle while the output does not stall; five register
// stages, each with its own valid bit, and an empty stage lets the pipeline
// fill while the output stalls.
// Reset clears the valid bits only; the data path holds no state between beats.
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Pipelined conversion of whole-degree hue and percent saturation and
// lightness to 8-bit red, green and blue.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter import hslrgb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hsl_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rgb_out_t m_data
);

    logic [4:0]         valid_reg, valid_next;
    stage_en_t          stage_en;

    logic [LEVEL_W-1:0] q_level;
    logic [LEVEL_W-1:0] p_level;
    logic [HUE_W-1:0]   t_red;
    logic [HUE_W-1:0]   t_green;
    logic [HUE_W-1:0]   t_blue;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en.s5 = !valid_reg[4] || m_ready;
        stage_en.s4 = !valid_reg[3] || stage_en.s5;
        stage_en.s3 = !valid_reg[2] || stage_en.s4;
        stage_en.s2 = !valid_reg[1] || stage_en.s3;
        stage_en.s1 = !valid_reg[0] || stage_en.s2;

        valid_next    = valid_reg;
        if (stage_en.s1) valid_next[0] = s_valid;
        if (stage_en.s2) valid_next[1] = valid_reg[0];
        if (stage_en.s3) valid_next[2] = valid_reg[1];
        if (stage_en.s4) valid_next[3] = valid_reg[2];
        if (stage_en.s5) valid_next[4] = valid_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    hslrgb_levels u_levels (
        .aclk     (aclk),
        .stage_en (stage_en),
        .in_data  (s_data),
        .q_level  (q_level),
        .p_level  (p_level),
        .t_red    (t_red),
        .t_green  (t_green),
        .t_blue   (t_blue)
    );

    hslrgb_chan u_chan_red (
        .aclk     (aclk),
        .stage_en (stage_en),
        .q_level  (q_level),
        .p_level  (p_level),
        .t_deg    (t_red),
        .chan     (m_data.red)
    );

    hslrgb_chan u_chan_green (
        .aclk     (aclk),
        .stage_en (stage_en),
        .q_level  (q_level),
        .p_level  (p_level),
        .t_deg    (t_green),
        .chan     (m_data.green)
    );

    hslrgb_chan u_chan_blue (
        .aclk     (aclk),
        .stage_en (stage_en),
        .q_level  (q_level),
        .p_level  (p_level),
        .t_deg    (t_blue),
        .chan     (m_data.blue)
    );

    assign s_ready = stage_en.s1;
    assign m_valid = valid_reg[4];

endmodule

// ===== hw/rtl/hslrgb_levels.sv =====
// ----------------------------------------------------------------------------
// HSL levels
// Input cleanup, the Q and P levels and the per-channel hue offsets.
// ----------------------------------------------------------------------------
module hslrgb_levels import hslrgb_pkg::*; (
    input  logic                 aclk,
    input  stage_en_t            stage_en,
    input  hsl_in_t              in_data,
    output logic [LEVEL_W-1:0]   q_level,
    output logic [LEVEL_W-1:0]   p_level,
    output logic [HUE_W-1:0]     t_red,
    output logic [HUE_W-1:0]     t_green,
    output logic [HUE_W-1:0]     t_blue
);

    logic [HUE_W-1:0]   hue_reg, hue_next;
    logic [PCT_W-1:0]   sat_reg, sat_next;
    logic [PCT_W-1:0]   lit_reg, lit_next;

    logic [LEVEL_W-1:0] q_reg, q_next;
    logic [LEVEL_W-1:0] p_reg, p_next;
    logic [HUE_W-1:0]   tr_reg, tr_next;
    logic [HUE_W-1:0]   tg_reg, tg_next;
    logic [HUE_W-1:0]   tb_reg, tb_next;

    logic [LEVEL_W-1:0] lit_sat;
    logic [LEVEL_W:0]   q_wide;
    logic [LEVEL_W:0]   lit_200;
    logic [HUE_W:0]     hue_plus_third;
    logic [HUE_W:0]     hue_plus_two;

    // Stage 1: wrap the hue once and clamp both percentages.
    always_comb begin
        hue_next = (in_data.hue_deg >= FULL_TURN) ? in_data.hue_deg - FULL_TURN
                                                  : in_data.hue_deg;
        sat_next = (in_data.sat_pct > PCT_ONE) ? PCT_ONE : in_data.sat_pct;
        lit_next = (in_data.light_pct > PCT_ONE) ? PCT_ONE : in_data.light_pct;
    end

    // Stage 2: Q and P in units of 1/10000, and the wrapped channel offsets.
    always_comb begin
        lit_sat = LEVEL_W'(lit_reg) * LEVEL_W'(sat_reg);
        if (lit_reg < PCT_HALF) begin
            q_wide = (LEVEL_W+1)'(lit_reg) * (LEVEL_W+1)'(PCT_ONE)
                   + (LEVEL_W+1)'(lit_sat);
        end else begin
            q_wide = (LEVEL_W+1)'(lit_reg) * (LEVEL_W+1)'(PCT_ONE)
                   + (LEVEL_W+1)'(sat_reg) * (LEVEL_W+1)'(PCT_ONE)
                   - (LEVEL_W+1)'(lit_sat);
        end
        lit_200 = (LEVEL_W+1)'(lit_reg) * (LEVEL_W+1)'(2 * PCT_ONE);
        q_next  = q_wide[LEVEL_W-1:0];
        p_next  = LEVEL_W'(lit_200 - q_wide);

        hue_plus_third = (HUE_W+1)'(hue_reg) + (HUE_W+1)'(THIRD_TURN);
        hue_plus_two   = (HUE_W+1)'(hue_reg) + (HUE_W+1)'(TWO_THIRDS);
        tr_next = (hue_plus_third >= (HUE_W+1)'(FULL_TURN))
                ? HUE_W'(hue_plus_third - (HUE_W+1)'(FULL_TURN))
                : hue_plus_third[HUE_W-1:0];
        tg_next = hue_reg;
        tb_next = (hue_plus_two >= (HUE_W+1)'(FULL_TURN))
                ? HUE_W'(hue_plus_two - (HUE_W+1)'(FULL_TURN))
                : hue_plus_two[HUE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s1) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            lit_reg <= lit_next;
        end
        if (stage_en.s2) begin
            q_reg  <= q_next;
            p_reg  <= p_next;
            tr_reg <= tr_next;
            tg_reg <= tg_next;
            tb_reg <= tb_next;
        end
    end

    assign q_level = q_reg;
    assign p_level = p_reg;
    assign t_red   = tr_reg;
    assign t_green = tg_reg;
    assign t_blue  = tb_reg;

endmodule

// ===== hw/rtl/hslrgb_chan.sv =====
// ----------------------------------------------------------------------------
// HSL channel
// Piecewise hue ramp for one channel and the exact scale to 8 bits.
// ----------------------------------------------------------------------------
module hslrgb_chan import hslrgb_pkg::*; (
    input  logic                 aclk,
    input  stage_en_t            stage_en,
    input  logic [LEVEL_W-1:0]   q_level,
    input  logic [LEVEL_W-1:0]   p_level,
    input  logic [HUE_W-1:0]     t_deg,
    output logic [7:0]           chan
);

    logic [RAMP_W-1:0]  ramp_reg, ramp_next;
    logic [8:0]         quot_reg, quot_next;
    logic [7:0]         chan_reg, chan_next;

    logic [LEVEL_W-1:0] span;
    logic [SLOPE_W-1:0] slope;
    logic [HUE_W-1:0]   fall;
    logic [SCALE_W-1:0] scaled;
    logic [QIN_W-1:0]   qin;
    logic [PROD_W-1:0]  prod;

    // Stage 3: ramp times 60 = 60*P + (Q-P)*d, d the degrees into the slope.
    // The flat part is d = 60, which gives 60*Q.
    always_comb begin
        span = q_level - p_level;
        fall = TWO_THIRDS - t_deg;
        priority if (t_deg < SIXTH_TURN) begin
            slope = t_deg[SLOPE_W-1:0];
        end else if (t_deg < HALF_TURN) begin
            slope = SLOPE_W'(SIXTH_TURN);
        end else if (t_deg < TWO_THIRDS) begin
            slope = fall[SLOPE_W-1:0];
        end else begin
            slope = '0;
        end
        ramp_next = RAMP_W'(p_level) * RAMP_W'(SIXTH_TURN)
                  + RAMP_W'(span) * RAMP_W'(slope);
    end

    // Stage 4: floor(ramp * 17 / 40000); the power-of-two part is a shift.
    always_comb begin
        scaled    = (SCALE_W'(ramp_reg) << 4) + SCALE_W'(ramp_reg);
        qin       = QIN_W'(scaled >> SCALE_SHIFT);
        prod      = PROD_W'(qin) * PROD_W'(RECIP_625);
        quot_next = prod[RECIP_SHIFT +: 9];
    end

    // Stage 5: clamp to 255 and output register.
    always_comb begin
        chan_next = (quot_reg > CHAN_MAX) ? CHAN_MAX[7:0] : quot_reg[7:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s3) begin
            ramp_reg <= ramp_next;
        end
        if (stage_en.s4) begin
            quot_reg <= quot_next;
        end
        if (stage_en.s5) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Sends directed and random colors through the converter under varying
// backpressure, predicts each RGB result exactly and checks it on arrival.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hslrgb_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned DRAIN_CYCLES     = 12;
    localparam int unsigned RANDOM_PER_PHASE = 376;
    localparam int unsigned RAMP_DIVISOR     = 600000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hsl_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rgb_out_t m_data;

    hsl_in_t     hsl_pending[$];
    rgb_out_t    rgb_expected[$];
    rgb_out_t    rgb_want;
    logic        s_taken            = 1'b0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned beats_total        = 0;
    int unsigned beats_in           = 0;
    int unsigned error_count        = 0;
    int unsigned cycle_count        = 0;

    hsl_to_rgb_converter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // Exact fixed-point conversion: Q and P in units of 1/10000, the ramp
    // carried times 60 so that no fraction appears before the final floor.
    function automatic rgb_out_t hsl_to_rgb(hsl_in_t color);
        int unsigned hue, sat, lit, q, p, ramp, angle;
        int unsigned offset[3];
        longint unsigned level;
        logic [7:0] chan[3];
        rgb_out_t rgb;
        hue = color.hue_deg;
        sat = color.sat_pct;
        lit = color.light_pct;
        if (hue >= FULL_TURN) hue -= FULL_TURN;
        if (sat > PCT_ONE) sat = PCT_ONE;
        if (lit > PCT_ONE) lit = PCT_ONE;
        if (lit < PCT_HALF)
            q = lit * (PCT_ONE + sat);
        else
            q = PCT_ONE * lit + PCT_ONE * sat - lit * sat;
        p = 2 * PCT_ONE * lit - q;
        offset[0] = hue + THIRD_TURN;
        offset[1] = hue;
        offset[2] = hue + FULL_TURN - THIRD_TURN;
        for (int i = 0; i < 3; i++) begin
            angle = offset[i];
            if (angle >= FULL_TURN) angle -= FULL_TURN;
            if (angle < SIXTH_TURN)
                ramp = p * SIXTH_TURN + (q - p) * angle;
            else if (angle < HALF_TURN)
                ramp = q * SIXTH_TURN;
            else if (angle < TWO_THIRDS)
                ramp = p * SIXTH_TURN + (q - p) * (TWO_THIRDS - angle);
            else
                ramp = p * SIXTH_TURN;
            level = longint'(ramp) * CHAN_MAX / RAMP_DIVISOR;
            if (level > CHAN_MAX) level = CHAN_MAX;
            chan[i] = level[7:0];
        end
        rgb.red   = chan[0];
        rgb.green = chan[1];
        rgb.blue  = chan[2];
        return rgb;
    endfunction

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_channel(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic queue_color(input int unsigned hue, input int unsigned sat,
                               input int unsigned lit);
        hsl_in_t color;
        color.hue_deg   = hue[HUE_W-1:0];
        color.sat_pct   = sat[PCT_W-1:0];
        color.light_pct = lit[PCT_W-1:0];
        hsl_pending.insert(hsl_pending.size(), color);
        beats_total++;
    endtask

    // Mostly legal colors; the rest use the full field widths to reach the
    // hue wrap and the saturation and lightness clamps.
    task automatic queue_random_color();
        if ($urandom_range(99) < 85)
            queue_color($urandom_range(359), $urandom_range(100), $urandom_range(100));
        else
            queue_color($urandom_range(511), $urandom_range(127), $urandom_range(127));
    endtask

    // Driver: a beat on s_valid holds until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_taken) begin
                if (hsl_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= hsl_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: predicts at input acceptance and checks at result acceptance.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            s_taken <= aresetn && s_valid && s_ready;
            if (aresetn && s_valid && s_ready) begin
                rgb_expected.insert(rgb_expected.size(), hsl_to_rgb(s_data));
                beats_in++;
            end
            if (aresetn && m_valid && m_ready) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch("result beat with no color outstanding");
                end else begin
                    rgb_want = rgb_expected.pop_front();
                    check_channel("red", m_data.red, rgb_want.red);
                    check_channel("green", m_data.green, rgb_want.green);
                    check_channel("blue", m_data.blue, rgb_want.blue);
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 25;
                    receiver_stall_pct = 79;
                end
                1: begin
                    sender_idle_pct    = 79;
                    receiver_stall_pct = 25;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            if (phase == 0) begin
                queue_color(0, 0, 0);
                queue_color(359, 100, 100);
                queue_color(0, 100, 50);
                queue_color(120, 100, 50);
                queue_color(240, 100, 50);
                queue_color(60, 100, 50);
                queue_color(180, 100, 50);
                queue_color(59, 73, 40);
                queue_color(239, 55, 61);
                queue_color(300, 100, 25);
                queue_color(1, 1, 1);
                queue_color(0, 0, 100);
                queue_color(0, 0, 50);
                queue_color(200, 100, 49);
                queue_color(200, 100, 50);
                queue_color(30, 37, 99);
                // Hue wrap at and beyond a full turn.
                queue_color(360, 80, 50);
                queue_color(511, 100, 50);
                queue_color(420, 90, 10);
                // Saturation and lightness above one clamp to one.
                queue_color(100, 127, 50);
                queue_color(100, 60, 127);
                queue_color(511, 127, 127);
                queue_color(150, 101, 101);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                queue_random_color();
            while (beats_in != beats_total || rgb_expected.size() != 0)
                @(posedge aclk);
        end
        // Let any stray result beat show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
